@@ rtl/token_scanner_keyword_hash_top_assert.svh @@
// Assertion macros used by the top level of the token scanner RTL.
`ifndef TOKEN_SCANNER_KEYWORD_HASH_TOP_ASSERT_SVH
`define TOKEN_SCANNER_KEYWORD_HASH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define TSKH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed (same cycle)");

// Next-cycle implication, checked on every rising edge outside reset.
`define TSKH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed (next cycle)");

`else

`define TSKH_ASSERT_SAME(label, ante, cons)
`define TSKH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/tskh_pkg.sv @@
// Shared types, constants and functions of the token scanner.
package tskh_pkg;

    localparam int CHAR_W    = 8;
    localparam int HASH_W    = 8;
    localparam int LEN_W     = 16;
    localparam int SUM_W     = 32;
    localparam int HASH_SIZE = 256;

    localparam logic [HASH_W-1:0] HASH_MASK   = HASH_W'(HASH_SIZE - 1);
    localparam logic [SUM_W-1:0]  WEIGHT_BASE = SUM_W'(119);

    // Byte codes with a special meaning.
    localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // One finished token.
    typedef struct packed {
        logic [LEN_W-1:0]  token_length;
        logic [HASH_W-1:0] token_hash;
        logic              was_quoted;
        logic              ended_by_end;
    } result_t;

    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_SEMI) ||
               (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
    endfunction

    // Fold the sum with arithmetic shifts of 10 and 20, then mask to the table size.
    function automatic logic [HASH_W-1:0] fold_hash(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] f;
        f = s ^ SUM_W'($signed(s) >>> 10) ^ SUM_W'($signed(s) >>> 20);
        return f[HASH_W-1:0] & HASH_MASK;
    endfunction

endpackage

@@ rtl/tskh_core.sv @@
// Token state and hash accumulator: one text byte per step.
module tskh_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [tskh_pkg::CHAR_W-1:0]     char_code,
    output logic                            emit,
    output tskh_pkg::result_t               result
);
    import tskh_pkg::*;

    logic             inside_token_reg, inside_token_next;
    logic             inside_quotes_reg, inside_quotes_next;
    logic [SUM_W-1:0] hash_sum_reg, hash_sum_next;
    logic [SUM_W-1:0] char_position_reg, char_position_next;

    logic [CHAR_W-1:0] lowered;
    logic [SUM_W-1:0]  char_ext;
    logic [SUM_W-1:0]  weight;
    logic [SUM_W-1:0]  take_sum;
    logic [SUM_W-1:0]  take_position;
    logic              sep;
    logic              by_end;

    // Weighted byte term. Outside a token the sum and position are zero,
    // so the same adder also starts a fresh token.
    always_comb
    begin
        lowered = char_code;
        if ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z))
        begin
            lowered = char_code + CASE_OFFSET;
        end
        char_ext      = {{(SUM_W - CHAR_W){lowered[CHAR_W-1]}}, lowered};
        weight        = WEIGHT_BASE + char_position_reg;
        take_sum      = hash_sum_reg + char_ext * weight;
        take_position = char_position_reg + SUM_W'(1);
        sep           = is_separator(char_code);
    end

    // Token state transitions.
    always_comb
    begin
        inside_token_next  = inside_token_reg;
        inside_quotes_next = inside_quotes_reg;
        hash_sum_next      = hash_sum_reg;
        char_position_next = char_position_reg;
        emit               = 1'b0;
        by_end             = 1'b0;
        if (step_en)
        begin
            priority if (char_code == CH_END)
            begin
                emit               = inside_token_reg;
                by_end             = 1'b1;
                inside_token_next  = 1'b0;
                inside_quotes_next = 1'b0;
                hash_sum_next      = '0;
                char_position_next = '0;
            end
            else if (!inside_token_reg)
            begin
                if (!sep)
                begin
                    inside_token_next = 1'b1;
                    if (char_code == CH_QUOTE)
                    begin
                        inside_quotes_next = 1'b1;
                    end
                    else
                    begin
                        inside_quotes_next = 1'b0;
                        hash_sum_next      = take_sum;
                        char_position_next = take_position;
                    end
                end
            end
            else if ((inside_quotes_reg && (char_code == CH_QUOTE)) ||
                     (!inside_quotes_reg && sep))
            begin
                emit               = 1'b1;
                inside_token_next  = 1'b0;
                inside_quotes_next = 1'b0;
                hash_sum_next      = '0;
                char_position_next = '0;
            end
            else
            begin
                hash_sum_next      = take_sum;
                char_position_next = take_position;
            end
        end
    end

    // Result fields taken from the state before this byte; ended_by_end comes from this byte.
    always_comb
    begin
        result.token_hash   = fold_hash(hash_sum_reg);
        result.token_length = (|char_position_reg[SUM_W-1:LEN_W]) ? '1 :
                              char_position_reg[LEN_W-1:0];
        result.was_quoted   = inside_quotes_reg;
        result.ended_by_end = by_end;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_token_reg  <= 1'b0;
            inside_quotes_reg <= 1'b0;
            hash_sum_reg      <= '0;
            char_position_reg <= '0;
        end
        else
        begin
            inside_token_reg  <= inside_token_next;
            inside_quotes_reg <= inside_quotes_next;
            hash_sum_reg      <= hash_sum_next;
            char_position_reg <= char_position_next;
        end
    end

endmodule

@@ rtl/token_scanner_keyword_hash_top.sv @@
// Top level of the case-insensitive keyword hash tokenizer.
//
//   Channel | Dir | tdata (low bit first)               | Side bands
//   s_axis  | in  | char_code[7:0]                      | none
//   m_axis  | out | token_hash[7:0], token_length[23:8] | tuser=was_quoted, tlast=ended_by_end
//
// A byte is held in the input register and is processed as it moves on;
// a token's result is then registered in the result register and shown on m_axis from there.
// One byte is taken every cycle while the output register is free or drained.
// A stalled output holds the result and the input register, and s_tready falls
// only when both are full. Reset clears all token state; no clearing pass.
module token_scanner_keyword_hash_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tskh_pkg::CHAR_W-1:0]     s_tdata,   // char_code[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tskh_pkg::HASH_W+tskh_pkg::LEN_W-1:0] m_tdata, // token_hash, token_length
    output logic                            m_tuser,   // was_quoted
    output logic                            m_tlast    // ended_by_end
);
    import tskh_pkg::*;

`include "token_scanner_keyword_hash_top_assert.svh"

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic              out_free;
    logic              step_en;
    logic              core_emit;
    result_t           core_result;

    // Handshake: the input register moves on whenever the result slot can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
    end

    tskh_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .char_code (in_char_reg),
        .emit      (core_emit),
        .result    (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= core_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && core_emit)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.token_length, out_data_reg.token_hash};
    assign m_tuser  = out_data_reg.was_quoted;
    assign m_tlast  = out_data_reg.ended_by_end;

    // A token is only closed by a byte that actually moves into the result slot.
    `TSKH_ASSERT_SAME(a_emit_needs_step, core_emit, step_en)
    // A byte held behind a stalled result stays put for the next cycle.
    `TSKH_ASSERT_NEXT(a_input_held, in_valid_reg && !out_free, in_valid_reg && $stable(in_char_reg))
    // An empty input register never blocks the slave side.
    `TSKH_ASSERT_SAME(a_ready_when_empty, !in_valid_reg, s_tready)

endmodule
